// ===== rtl/core/mvn_pkg.sv =====
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared constants, codes and fixed-point helpers for the MVN density block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvn_pkg;

    localparam int DEF_MAX_DIM = 8;

    // operand width of the shared multiplier
    localparam int MUL_W = 34;

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // register indexes
    localparam logic [0:0] CFG_DIMENSION  = 1'b0;
    localparam logic [0:0] CFG_LOG_OUTPUT = 1'b1;

    localparam logic [31:0] LN2_Q32          = 32'd2977044472;
    localparam logic [32:0] INV_LN2_Q32      = 33'd6196328019;
    localparam logic [31:0] HALF_LOG_2PI_Q32 = 32'd3946810947;
    localparam logic [62:0] SUM_CAP          = '1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // floor(2^32 / k) for the Taylor term divisors
    function automatic logic [32:0] recip_q32(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/mvn_log_density_cholinv.sv =====
// ----------------------------------------------------------------------------
// mvn_log_density_cholinv
// Multivariate normal log density from an inverse Cholesky factor, Q15.16.
//
// Load requests and samples that do not close a column leave busy low. A
// closing sample (sample count not saturated) keeps busy high while L*c is
// formed, one factor product per cycle on the shared multiplier, then a
// square and a saturating add per row. Finish normalizes each positive diagonal
// entry one bit a cycle and takes 16 squarings for its log, flags a bad entry,
// then runs exp only for density output in range; done is high for one cycle
// as busy falls. The receiver cannot stall. Async reset clears sums, count and
// sample column, dimension to 8 and log mode on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvn_log_density_cholinv import mvn_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [31:0] value,
    input  logic signed [31:0] mean,
    // configuration
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    // result
    output logic               done,
    output logic signed [63:0] log_density,
    output logic [31:0]        density,
    output logic               bad_diagonal
);

    localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int QW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = 49 + RW;     // sum of 48-bit shifted products
    localparam int SL_W  = 22 + RW;     // sum of 21-bit logs
    localparam int CT_W  = QW + 33;     // rounded n*q*c term
    localparam int PW    = 2 * MUL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_ABS_RUN, S_ABS_SQ, S_ABS_SUM,
        S_DG_RD, S_DG_WAIT, S_LN_NORM, S_LN_SQ, S_LN_CHK, S_LN_MUL, S_LN_ACC,
        S_NQ, S_CT, S_AN, S_LD,
        S_EX_Y, S_EX_F, S_EX_R, S_EX_T, S_EX_D, S_EX_C, S_EX_SH,
        S_EMIT
    } state_t;

    state_t state_reg;

    // configuration and accumulated state
    logic [3:0]         dim_reg;
    logic               logout_reg;
    logic signed [31:0] cc_reg [MAX_DIM];
    logic [62:0]        sum_reg;
    logic [15:0]        count_reg;

    // column absorb pipeline
    logic [QW-1:0]      i_reg;
    logic [QW-1:0]      iss_reg;
    logic               issuing_reg;
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [RW-1:0]      s1_j_reg;
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0] ki_reg;

    // log of diagonal
    logic               bad_reg;
    logic [31:0]        m_reg;
    logic [4:0]         p_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         bit_reg;
    logic signed [SL_W-1:0] sumlog_reg;
    logic [CT_W-1:0]    cterm_reg;
    logic signed [63:0] ld_reg;

    // exp
    logic signed [7:0]  ip_reg;
    logic [29:0]        r_reg;
    logic [30:0]        term_reg;
    logic [31:0]        sume_reg;
    logic [30:0]        x_reg;
    logic [3:0]         k_reg;
    logic [31:0]        dens_reg;

    // result registers
    logic               done_reg;
    logic signed [63:0] log_density_reg;
    logic [31:0]        density_reg;
    logic               bad_out_reg;

    // shared unit and factor store
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PW-1:0]    prod;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [31:0]             rdata;

    logic            accept;
    logic [QW-1:0]   q_c;
    logic [QW-1:0]   q_last;
    logic            diag_last;
    logic signed [32:0] diff_c;

    logic signed [ACC_W-1:0] acc_sum;
    logic [63:0]        sum_add;
    logic [62:0]        sum_sat;
    logic [31:0]        mm_c;
    logic signed [5:0]  pm16_c;
    logic signed [21:0] log2v_c;
    logic signed [PW-1:0] ln_rnd;
    logic signed [PW-1:0] ct_rnd;
    logic signed [63:0] ld_c;
    logic [30:0]        t1_c;
    logic [30:0]        q0_c;
    logic [34:0]        rem_c;
    logic [30:0]        term_c;
    logic signed [8:0]  sh_c;
    logic [8:0]         nsh_c;
    logic [32:0]        upv_c;
    logic [31:0]        dens_sh_c;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        if (dim_reg == 4'd0)
            q_c = QW'(1);
        else if (int'(dim_reg) > MAX_DIM)
            q_c = QW'(MAX_DIM);
        else
            q_c = QW'(dim_reg);
    end

    assign q_last    = q_c - QW'(1);
    assign diag_last = (i_reg == q_last);
    assign diff_c    = 33'(value) - 33'(mean);

    // factor writes go straight to the store, out-of-range loads dropped
    assign ram_we    = accept && (operation == OP_LOAD)
                       && (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign ram_waddr = AW'(int'(row) * MAX_DIM + int'(col));

    always_comb
    begin
        case (state_reg)
            S_ABS_RUN: ram_raddr = AW'(int'(i_reg) * MAX_DIM + int'(iss_reg));
            S_DG_RD:   ram_raddr = AW'(int'(i_reg) * MAX_DIM + int'(i_reg));
            default:   ram_raddr = '0;
        endcase
    end

    mvn_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_factor (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    mvn_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // product taps, each valid in the state after its issue; acc_sum is taken within S_ABS_RUN
    assign acc_sum = acc_reg + ACC_W'(signed'(prod[63:16]));
    assign sum_add = {1'b0, sum_reg} + 64'(prod[62:16]);
    assign sum_sat = (sum_add > {1'b0, SUM_CAP}) ? SUM_CAP : sum_add[62:0];
    assign mm_c    = prod[61:30];
    assign pm16_c  = signed'(6'(p_reg) - 6'd16);
    assign log2v_c = signed'({pm16_c, frac_reg});
    assign ln_rnd  = prod + signed'(PW'(33'h080000000));
    assign ct_rnd  = prod + signed'(PW'(17'h08000));
    assign ld_c    = signed'(prod[63:0]) - signed'(64'(cterm_reg))
                     - signed'(64'(sum_reg[62:1]));
    assign t1_c    = prod[60:30];
    assign q0_c    = prod[62:32];
    assign rem_c   = 35'(x_reg) - 35'(q0_c) * 35'(k_reg);
    assign term_c  = (rem_c >= 35'(k_reg)) ? q0_c + 31'd1 : q0_c;

    // final scale of 2^f by 2^(ip-14)
    assign sh_c  = 9'(ip_reg) - 9'sd14;
    assign nsh_c = 9'(-sh_c);
    assign upv_c = sh_c[0] ? {sume_reg, 1'b0} : {1'b0, sume_reg};

    always_comb
    begin
        if (ip_reg >= 8'sd16)
            dens_sh_c = 32'hFFFF_FFFF;
        else if (sh_c >= 9'sd0)
            dens_sh_c = upv_c[32] ? 32'hFFFF_FFFF : upv_c[31:0];
        else if (nsh_c >= 9'd32)
            dens_sh_c = 32'd0;
        else
            dens_sh_c = sume_reg >> nsh_c[4:0];
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ABS_RUN:
            begin
                mul_a = MUL_W'(signed'(rdata));
                mul_b = MUL_W'(cc_reg[s1_j_reg]);
            end
            S_ABS_SQ:
            begin
                mul_a = MUL_W'(ki_reg);
                mul_b = MUL_W'(ki_reg);
            end
            S_LN_SQ:
            begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_LN_MUL:
            begin
                mul_a = MUL_W'(log2v_c);
                mul_b = MUL_W'(LN2_Q32);
            end
            S_NQ:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(q_c);
            end
            S_CT:
            begin
                mul_a = MUL_W'(prod[QW+15:0]);
                mul_b = MUL_W'(HALF_LOG_2PI_Q32);
            end
            S_AN:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(sumlog_reg);
            end
            S_EX_Y:
            begin
                mul_a = MUL_W'(signed'(ld_reg[22:0]));
                mul_b = MUL_W'(INV_LN2_Q32);
            end
            S_EX_F:
            begin
                mul_a = MUL_W'(prod[47:32]);
                mul_b = MUL_W'(LN2_Q32);
            end
            S_EX_T:
            begin
                mul_a = MUL_W'(term_reg);
                mul_b = MUL_W'(r_reg);
            end
            S_EX_D:
            begin
                mul_a = MUL_W'(t1_c);
                mul_b = MUL_W'(recip_q32(k_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dim_reg         <= 4'd8;
            logout_reg      <= 1'b1;
            for (int n = 0; n < MAX_DIM; n++)
            begin
                cc_reg[n] <= '0;
            end
            sum_reg         <= '0;
            count_reg       <= '0;
            i_reg           <= '0;
            iss_reg         <= '0;
            issuing_reg     <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
            s1_j_reg        <= '0;
            s2_valid_reg    <= 1'b0;
            s2_last_reg     <= 1'b0;
            acc_reg         <= '0;
            ki_reg          <= '0;
            bad_reg         <= 1'b0;
            m_reg           <= '0;
            p_reg           <= '0;
            frac_reg        <= '0;
            bit_reg         <= '0;
            sumlog_reg      <= '0;
            cterm_reg       <= '0;
            ld_reg          <= '0;
            ip_reg          <= '0;
            r_reg           <= '0;
            term_reg        <= '0;
            sume_reg        <= '0;
            x_reg           <= '0;
            k_reg           <= '0;
            dens_reg        <= '0;
            done_reg        <= 1'b0;
            log_density_reg <= '0;
            density_reg     <= '0;
            bad_out_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DIMENSION:  dim_reg    <= cfg_data;
                    CFG_LOG_OUTPUT: logout_reg <= cfg_data[0];
                    default:        dim_reg    <= dim_reg;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (operation == OP_SAMPLE) && (int'(row) < int'(q_c)))
                    begin
                        cc_reg[RW'(row)] <= sat32(64'(diff_c));
                        // the last row closes the column
                        if ((int'(row) == int'(q_last)) && (count_reg != 16'hFFFF))
                        begin
                            i_reg        <= '0;
                            iss_reg      <= '0;
                            issuing_reg  <= 1'b1;
                            s1_valid_reg <= 1'b0;
                            s2_valid_reg <= 1'b0;
                            acc_reg      <= '0;
                            state_reg    <= S_ABS_RUN;
                        end
                    end
                    else if (accept && (operation == OP_FINISH))
                    begin
                        i_reg      <= '0;
                        bad_reg    <= 1'b0;
                        sumlog_reg <= '0;
                        state_reg  <= S_DG_RD;
                    end
                end

                // one row of L*c: read, multiply, accumulate
                S_ABS_RUN:
                begin
                    if (issuing_reg)
                    begin
                        iss_reg <= iss_reg + QW'(1);
                        if (iss_reg == q_last)
                            issuing_reg <= 1'b0;
                    end
                    s1_valid_reg <= issuing_reg;
                    s1_last_reg  <= (iss_reg == q_last);
                    s1_j_reg     <= RW'(iss_reg);
                    s2_valid_reg <= s1_valid_reg;
                    s2_last_reg  <= s1_last_reg;
                    if (s2_valid_reg)
                    begin
                        if (s2_last_reg)
                        begin
                            ki_reg    <= sat32(64'(acc_sum));
                            state_reg <= S_ABS_SQ;
                        end
                        else
                        begin
                            acc_reg <= acc_sum;
                        end
                    end
                end

                S_ABS_SQ:
                begin
                    state_reg <= S_ABS_SUM;
                end

                S_ABS_SUM:
                begin
                    sum_reg <= sum_sat;
                    if (diag_last)
                    begin
                        count_reg <= count_reg + 16'd1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg        <= i_reg + QW'(1);
                        iss_reg      <= '0;
                        issuing_reg  <= 1'b1;
                        s1_valid_reg <= 1'b0;
                        s2_valid_reg <= 1'b0;
                        acc_reg      <= '0;
                        state_reg    <= S_ABS_RUN;
                    end
                end

                S_DG_RD:
                begin
                    state_reg <= S_DG_WAIT;
                end

                S_DG_WAIT:
                begin
                    if (rdata[31] || (rdata == 32'd0))
                    begin
                        bad_reg <= 1'b1;
                        if (diag_last)
                        begin
                            state_reg <= S_NQ;
                        end
                        else
                        begin
                            i_reg     <= i_reg + QW'(1);
                            state_reg <= S_DG_RD;
                        end
                    end
                    else
                    begin
                        m_reg     <= {1'b0, rdata[30:0]};
                        p_reg     <= 5'd30;
                        state_reg <= S_LN_NORM;
                    end
                end

                // bring the leading one to bit 30
                S_LN_NORM:
                begin
                    if (m_reg[30])
                    begin
                        frac_reg  <= '0;
                        bit_reg   <= '0;
                        state_reg <= S_LN_SQ;
                    end
                    else
                    begin
                        m_reg <= {m_reg[30:0], 1'b0};
                        p_reg <= p_reg - 5'd1;
                    end
                end

                S_LN_SQ:
                begin
                    state_reg <= S_LN_CHK;
                end

                S_LN_CHK:
                begin
                    if (mm_c[31])
                    begin
                        m_reg    <= {1'b0, mm_c[31:1]};
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= mm_c;
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    bit_reg <= bit_reg + 4'd1;
                    if (bit_reg == 4'd15)
                        state_reg <= S_LN_MUL;
                    else
                        state_reg <= S_LN_SQ;
                end

                S_LN_MUL:
                begin
                    state_reg <= S_LN_ACC;
                end

                S_LN_ACC:
                begin
                    sumlog_reg <= sumlog_reg + SL_W'(signed'(ln_rnd[52:32]));
                    if (diag_last)
                    begin
                        state_reg <= S_NQ;
                    end
                    else
                    begin
                        i_reg     <= i_reg + QW'(1);
                        state_reg <= S_DG_RD;
                    end
                end

                S_NQ:
                begin
                    state_reg <= S_CT;
                end

                S_CT:
                begin
                    state_reg <= S_AN;
                end

                S_AN:
                begin
                    cterm_reg <= ct_rnd[CT_W+15:16];
                    state_reg <= S_LD;
                end

                S_LD:
                begin
                    if (bad_reg)
                    begin
                        ld_reg    <= {1'b1, 63'd0};
                        dens_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        ld_reg <= ld_c;
                        if (logout_reg)
                        begin
                            dens_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else if (ld_c >= 64'sd4194304)
                        begin
                            dens_reg  <= 32'hFFFF_FFFF;
                            state_reg <= S_EMIT;
                        end
                        else if (ld_c <= -64'sd4194304)
                        begin
                            dens_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_EX_Y;
                        end
                    end
                end

                S_EX_Y:
                begin
                    state_reg <= S_EX_F;
                end

                // y = ld/ln2: integer part kept, fraction scaled by ln2
                S_EX_F:
                begin
                    ip_reg    <= signed'(prod[55:48]);
                    state_reg <= S_EX_R;
                end

                S_EX_R:
                begin
                    r_reg     <= prod[47:18];
                    term_reg  <= 31'h4000_0000;
                    sume_reg  <= 32'h4000_0000;
                    k_reg     <= 4'd1;
                    state_reg <= S_EX_T;
                end

                S_EX_T:
                begin
                    state_reg <= S_EX_D;
                end

                S_EX_D:
                begin
                    x_reg     <= t1_c;
                    state_reg <= S_EX_C;
                end

                // reciprocal quotient, one step of correction
                S_EX_C:
                begin
                    term_reg <= term_c;
                    sume_reg <= sume_reg + 32'(term_c);
                    k_reg    <= k_reg + 4'd1;
                    if (k_reg == 4'd12)
                        state_reg <= S_EX_SH;
                    else
                        state_reg <= S_EX_T;
                end

                S_EX_SH:
                begin
                    dens_reg  <= dens_sh_c;
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    done_reg        <= 1'b1;
                    log_density_reg <= ld_reg;
                    density_reg     <= dens_reg;
                    bad_out_reg     <= bad_reg;
                    sum_reg         <= '0;
                    count_reg       <= '0;
                    for (int n = 0; n < MAX_DIM; n++)
                    begin
                        cc_reg[n] <= '0;
                    end
                    state_reg       <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign log_density  = log_density_reg;
    assign density      = density_reg;
    assign bad_diagonal = bad_out_reg;

endmodule

// ===== rtl/core/mvn_ram.sv =====
// ----------------------------------------------------------------------------
// mvn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mvn_mul.sv =====
// ----------------------------------------------------------------------------
// mvn_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvn_mul import mvn_pkg::*; (
    input  logic                        clk,
    input  logic signed [MUL_W-1:0]     a,
    input  logic signed [MUL_W-1:0]     b,
    output logic signed [2*MUL_W-1:0]   prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
